// ----- rtl/core/evad_pkg.sv -----
// ---------------------------------------------------------------------------
// evad_pkg
// Shared types and constants for the energy end-of-speech detector.
// ---------------------------------------------------------------------------
package evad_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SQUARE_W    = 31;   // largest square is 2**30
   localparam int THRESH_W    = 31;
   localparam int HANG_W      = 8;
   localparam int WARMUP_W    = 16;
   localparam int SEEN_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int RSP_DATA_W  = 16;

   localparam int MAX_CHUNK_SAMPLES_DEF = 4096;

   localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(1000000);
   localparam logic [HANG_W-1:0]   HANG_RST   = HANG_W'(28);
   localparam logic [WARMUP_W-1:0] WARMUP_RST = WARMUP_W'(11200);

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HANG   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP = 2'd2;

   typedef struct packed {
      logic [THRESH_W-1:0] threshold;
      logic [HANG_W-1:0]   hangover;
      logic [WARMUP_W-1:0] warmup;
   } cfg_type;

   // one squared sample on its way to the accumulator
   typedef struct packed {
      logic [SQUARE_W-1:0] square;
      logic                last;
   } sq_beat_type;

   typedef struct packed {
      logic              end_of_speech;
      logic [HANG_W-1:0] silence_run;
      logic              speech_started;
      logic              chunk_voiced;
   } result_type;

endpackage

// ----- rtl/core/evad_square.sv -----
// ---------------------------------------------------------------------------
// evad_square
// Input register and squaring stage, with per-stage valid/ready.
// ---------------------------------------------------------------------------
module evad_square (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [evad_pkg::SAMPLE_W-1:0] in_sample,
   input  logic                               in_last,
   output logic                               sq_valid,
   output evad_pkg::sq_beat_type              sq_beat,
   input  logic                               sq_take
);

   logic                                 a_valid_ff, a_valid_in;
   logic signed [evad_pkg::SAMPLE_W-1:0] a_sample_ff;
   logic                                 a_last_ff;
   logic                                 b_valid_ff, b_valid_in;
   evad_pkg::sq_beat_type                b_beat_ff, b_beat_in;
   logic                                 a_ready, b_ready;
   logic signed [2*evad_pkg::SAMPLE_W-1:0] product;

   assign b_ready  = !b_valid_ff || sq_take;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign product = a_sample_ff * a_sample_ff;

   always_comb begin
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_beat_in.square = product[evad_pkg::SQUARE_W-1:0];
      b_beat_in.last   = a_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_sample_ff <= in_sample;
         a_last_ff   <= in_last;
      end
      if (b_ready && a_valid_ff) begin
         b_beat_ff <= b_beat_in;
      end
   end

   assign sq_valid = b_valid_ff;
   assign sq_beat  = b_beat_ff;

endmodule

// ----- rtl/core/evad_decide.sv -----
// ---------------------------------------------------------------------------
// evad_decide
// Chunk energy accumulator, speech state tracking and result register.
// ---------------------------------------------------------------------------
module evad_decide #(
   parameter int MaxChunkSamples = evad_pkg::MAX_CHUNK_SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  evad_pkg::cfg_type     cfg,
   input  logic                  sq_valid,
   input  evad_pkg::sq_beat_type sq_beat,
   output logic                  sq_take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output evad_pkg::result_type  rsp_result
);

   localparam int MarginW = evad_pkg::SQUARE_W + 1 + $clog2(MaxChunkSamples);
   localparam int LenW    = $clog2(MaxChunkSamples + 1);
   localparam int ExtW    = MarginW - evad_pkg::SQUARE_W;

   logic signed [MarginW-1:0]     margin_ff, margin_in, margin_sum;
   logic [LenW-1:0]               len_ff, len_in, len_next;
   logic [evad_pkg::SEEN_W-1:0]   seen_ff, seen_in;
   logic [evad_pkg::HANG_W-1:0]   silent_ff, silent_in, silent_inc;
   logic                          armed_ff, armed_in;
   logic                          speech_ff, speech_in;
   logic                          finished_ff, finished_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   evad_pkg::result_type          rsp_result_ff, rsp_result_in;
   logic                          chunk_end, emit, rsp_free, voiced;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign len_next   = len_ff + LenW'(1);
   assign chunk_end  = sq_beat.last || (len_next >= LenW'(MaxChunkSamples));
   assign emit       = sq_valid && !finished_ff && chunk_end;
   assign sq_take    = sq_valid && (!emit || rsp_free);

   assign margin_sum = margin_ff
                     + $signed({{ExtW{1'b0}}, sq_beat.square})
                     - $signed({{ExtW{1'b0}}, cfg.threshold});
   assign voiced     = !margin_sum[MarginW-1] && (|margin_sum);
   assign silent_inc = (silent_ff == '1) ? silent_ff : silent_ff + 1'b1;

   always_comb begin
      margin_in   = margin_ff;
      len_in      = len_ff;
      seen_in     = seen_ff;
      silent_in   = silent_ff;
      armed_in    = armed_ff;
      speech_in   = speech_ff;
      finished_in = finished_ff;

      if (sq_take && !finished_ff) begin
         seen_in = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
         if (!chunk_end) begin
            margin_in = margin_sum;
            len_in    = len_next;
         end else begin
            margin_in = '0;
            len_in    = '0;
            if (armed_ff) begin
               if (!speech_ff) begin
                  speech_in = voiced;
               end else if (!voiced) begin
                  silent_in = silent_inc;
                  if (silent_inc >= cfg.hangover) begin
                     finished_in = 1'b1;
                     silent_in   = '0;
                  end
               end else begin
                  silent_in = '0;
               end
            end
            // arm after this chunk's own decision
            if (seen_in >= cfg.warmup) begin
               armed_in = 1'b1;
            end
         end
      end

      rsp_result_in.chunk_voiced   = voiced;
      rsp_result_in.speech_started = speech_in;
      rsp_result_in.silence_run    = silent_in;
      rsp_result_in.end_of_speech  = finished_in;

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (emit && sq_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff    <= '0;
         len_ff       <= '0;
         seen_ff      <= '0;
         silent_ff    <= '0;
         armed_ff     <= 1'b0;
         speech_ff    <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         margin_ff    <= margin_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         silent_ff    <= silent_in;
         armed_ff     <= armed_in;
         speech_ff    <= speech_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && sq_take) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

// ----- rtl/core/energy_vad_end_of_speech_core.sv -----
// ---------------------------------------------------------------------------
// energy_vad_end_of_speech_core
// Energy-threshold voice activity detector that flags the end of an utterance.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata = sample, tlast = last_in_chunk
//   rsp      out  rsp_tvalid/tready     tdata = chunk result, one beat a chunk until end of speech
//   csr      in   csr_valid/csr_ready   csr_index, csr_data
//
// One sample beat is taken every cycle while the pipeline does not stall. A
// chunk result passes through the input register, the squarer register and
// the result register after the edge that takes its last sample beat. While
// a result waits, mid-chunk beats still flow into the accumulator; the next
// chunk-end beat holds in the squarer register, and the input stalls once the
// input register behind it is full as well. Reset is synchronous and clears
// the valid flags and detector state and loads the register defaults. Once
// end of speech is flagged, sample beats are taken and dropped until reset.
// ---------------------------------------------------------------------------
module energy_vad_end_of_speech_core #(
   parameter int MaxChunkSamples = evad_pkg::MAX_CHUNK_SAMPLES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [evad_pkg::SAMPLE_W-1:0]         req_tdata,  // [15:0] sample
   input  logic                                  req_tlast,  // last_in_chunk
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] chunk_voiced, [1] speech_started, [9:2] silence_run,
   // [10] end_of_speech, [15:11] zero
   output logic [evad_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [evad_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [evad_pkg::THRESH_W-1:0]         csr_data
);

   evad_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  sq_valid, sq_take;
   evad_pkg::sq_beat_type sq_beat;
   evad_pkg::result_type  result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            evad_pkg::CSR_THRESH: cfg_in.threshold = csr_data;
            evad_pkg::CSR_HANG:   cfg_in.hangover  = csr_data[evad_pkg::HANG_W-1:0];
            evad_pkg::CSR_WARMUP: cfg_in.warmup    = csr_data[evad_pkg::WARMUP_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= evad_pkg::THRESH_RST;
         cfg_ff.hangover  <= evad_pkg::HANG_RST;
         cfg_ff.warmup    <= evad_pkg::WARMUP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   evad_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample ($signed(req_tdata)),
      .in_last   (req_tlast),
      .sq_valid  (sq_valid),
      .sq_beat   (sq_beat),
      .sq_take   (sq_take)
   );

   evad_decide #(
      .MaxChunkSamples (MaxChunkSamples)
   ) u_decide (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .sq_valid   (sq_valid),
      .sq_beat    (sq_beat),
      .sq_take    (sq_take),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {{(evad_pkg::RSP_DATA_W - $bits(result)){1'b0}}, result};

endmodule
